### sv/u8dw_pkg.sv
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types, constants and functions of the UTF-8 display width counter.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  localparam int TOTAL_BITS  = 15;
  localparam int CP_W        = 21;
  localparam int CW_W        = 2;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_FIELD_W = CP_W + CW_W + TOTAL_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int NUM_WIDE    = 30;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX   = {TOTAL_BITS{1'b1}};
  localparam logic [CP_W-1:0]       REPLACEMENT = CP_W'(24'h00FFFD);

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  localparam logic [CP_W-1:0] WIDE_LO [NUM_WIDE] = '{
    21'h04E00, 21'h03400, 21'h20000, 21'h30000, 21'h0F900, 21'h2F800,
    21'h01100, 21'h0AC00, 21'h0D7B0, 21'h03000, 21'h0FF00, 21'h02E80,
    21'h02F00, 21'h031C0, 21'h02FF0, 21'h0FE10, 21'h0FE30, 21'h1F600,
    21'h1F300, 21'h1F680, 21'h1F1E0, 21'h02600, 21'h02700, 21'h1F900,
    21'h1FA00, 21'h1FA70, 21'h03200, 21'h03300, 21'hF0000, 21'h100000
  };
  localparam logic [CP_W-1:0] WIDE_HI [NUM_WIDE] = '{
    21'h09FFF, 21'h04DBF, 21'h2FFFD, 21'h3FFFD, 21'h0FAFF, 21'h2FA1F,
    21'h011FF, 21'h0D7AF, 21'h0D7FF, 21'h0303F, 21'h0FFEF, 21'h02EFF,
    21'h02FDF, 21'h031EF, 21'h02FFF, 21'h0FE1F, 21'h0FE4F, 21'h1F64F,
    21'h1F5FF, 21'h1F6FF, 21'h1F1FF, 21'h026FF, 21'h027BF, 21'h1F9FF,
    21'h1FA6F, 21'h1FAFF, 21'h032FF, 21'h033FF, 21'hFFFFD, 21'h10FFFD
  };

  // One decode job: the bytes of a finished sequence, or of a cut-off tail
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            eot;
  } job_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_1;
    if (b[7] == 1'b0)               len = LEN_1;
    else if (b[7:5] == 3'b110)      len = LEN_2;
    else if (b[7:4] == 4'b1110)     len = LEN_3;
    else if (b[7:3] == 5'b11110)    len = LEN_4;
    return len;
  endfunction

  function automatic logic [CW_W-1:0] glyph_width(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_WIDE; k++) begin
      if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k]) hit = 1'b1;
    end
    return hit ? CW_W'(2) : CW_W'(1);
  endfunction

endpackage

### sv/u8dw_front.sv
// ----------------------------------------------------------------------------
// u8dw_front
// Byte intake: buffers an open sequence and hands complete jobs to the queue.
// ----------------------------------------------------------------------------
module u8dw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          byte_val,
  input  logic                byte_eot,
  output logic                job_vld,
  output u8dw_pkg::job_t      job
);

  logic [2:0][7:0] pend_r;
  logic [1:0]      pcnt_r;
  logic [1:0]      pcnt_nxt;
  logic [2:0]      exp_r;
  logic [2:0]      exp_nxt;
  logic [2:0]      n;
  logic [2:0]      blen;
  logic            push;

  always_comb begin
    job.bytes = {8'h00, pend_r};
    job.bytes[pcnt_r] = byte_val;
    n         = {1'b0, pcnt_r} + 3'd1;
    job.n     = n;
    job.eot   = byte_eot;
    blen      = u8dw_pkg::lead_length(byte_val);
    push      = 1'b0;
    pcnt_nxt  = pcnt_r;
    exp_nxt   = exp_r;
    if (byte_eot) begin
      push = 1'b1;
    end else if (pcnt_r == 2'd0) begin
      if (blen == u8dw_pkg::LEN_1) push = 1'b1;
      else exp_nxt = blen;
    end else if (n >= exp_r) begin
      push = 1'b1;
    end
    if (push) begin
      pcnt_nxt = 2'd0;
      exp_nxt  = 3'd0;
    end else begin
      pcnt_nxt = n[1:0];
    end
    job_vld = byte_vld && push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      exp_r  <= 3'd0;
    end else if (byte_vld) begin
      pcnt_r <= pcnt_nxt;
      exp_r  <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && !push) pend_r[pcnt_r] <= byte_val;
  end

endmodule

### sv/u8dw_queue.sv
// ----------------------------------------------------------------------------
// u8dw_queue
// Two-entry job queue between intake and decoder.
// ----------------------------------------------------------------------------
module u8dw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  u8dw_pkg::job_t wr_job,
  output logic           full,
  output logic           rd_vld,
  input  logic           rd_en,
  output u8dw_pkg::job_t rd_job
);

  u8dw_pkg::job_t slot_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  logic           do_wr;
  logic           do_rd;

  assign full   = (cnt_r == 2'd2);
  assign rd_vld = (cnt_r != 2'd0);
  assign rd_job = slot_r[rp_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && rd_vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 2'd1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wp_r] <= wr_job;
  end

endmodule

### sv/u8dw_back.sv
// ----------------------------------------------------------------------------
// u8dw_back
// Decoder: walks a job one code point a cycle unless stalled; sizes and sums.
// ----------------------------------------------------------------------------
module u8dw_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_vld,
  input  u8dw_pkg::job_t                      q_job,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [u8dw_pkg::CP_W-1:0]           cp_o,
  output logic [u8dw_pkg::CW_W-1:0]           cw_o,
  output logic [u8dw_pkg::TOTAL_BITS-1:0]     run_o,
  output logic                                last_o
);

  u8dw_pkg::job_t                    job_r;
  logic                              busy_r;
  logic [2:0]                        pos_r;
  logic [2:0]                        pos_nxt;
  logic [u8dw_pkg::TOTAL_BITS-1:0]   tot_r;
  logic [u8dw_pkg::TOTAL_BITS-1:0]   tot_nxt;
  logic [u8dw_pkg::TOTAL_BITS:0]     sum;
  logic                              vld_r;
  logic [u8dw_pkg::CP_W-1:0]         cp_r;
  logic [u8dw_pkg::CW_W-1:0]         cw_r;
  logic [u8dw_pkg::TOTAL_BITS-1:0]   run_r;
  logic                              last_r;

  logic [7:0]                        lead;
  logic [7:0]                        b1;
  logic [7:0]                        b2;
  logic [7:0]                        b3;
  logic [2:0]                        i;
  logic [2:0]                        len;
  logic [3:0]                        reach;
  logic [u8dw_pkg::CP_W-1:0]         cp;
  logic [u8dw_pkg::CW_W-1:0]         cw;
  logic                              done;
  logic                              step;

  always_comb begin
    lead  = job_r.bytes[pos_r[1:0]];
    i     = pos_r + 3'd1;
    b1    = job_r.bytes[i[1:0]];
    b2    = job_r.bytes[2'(i[1:0] + 2'd1)];
    b3    = job_r.bytes[2'(i[1:0] + 2'd2)];
    len   = u8dw_pkg::lead_length(lead);
    reach = {1'b0, i} + {1'b0, len} - 4'd1;
    pos_nxt = i;
    if (lead[7] == 1'b0) begin
      cp = u8dw_pkg::CP_W'(lead);
    end else if (len == u8dw_pkg::LEN_1 || reach > {1'b0, job_r.n}) begin
      cp = u8dw_pkg::REPLACEMENT;
    end else begin
      pos_nxt = reach[2:0];
      case (len)
        u8dw_pkg::LEN_2: cp = u8dw_pkg::CP_W'({lead[4:0], b1[5:0]});
        u8dw_pkg::LEN_3: cp = u8dw_pkg::CP_W'({lead[3:0], b1[5:0], b2[5:0]});
        default:         cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
      endcase
    end
    cw   = u8dw_pkg::glyph_width(cp);
    sum  = {1'b0, tot_r} + (u8dw_pkg::TOTAL_BITS+1)'(cw);
    tot_nxt = (sum > {1'b0, u8dw_pkg::TOTAL_MAX}) ? u8dw_pkg::TOTAL_MAX
                                                  : sum[u8dw_pkg::TOTAL_BITS-1:0];
    done = (pos_nxt >= job_r.n);
    step = busy_r && (!vld_r || out_tready);
    q_pop = q_vld && (!busy_r || (step && done));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      tot_r  <= '0;
    end else begin
      if (vld_r && out_tready) vld_r <= 1'b0;
      if (step) begin
        vld_r <= 1'b1;
        tot_r <= (job_r.eot && done) ? '0 : tot_nxt;
        if (done) busy_r <= 1'b0;
      end
      if (q_pop) busy_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pos_r  <= pos_nxt;
      cp_r   <= cp;
      cw_r   <= cw;
      run_r  <= tot_nxt;
      last_r <= job_r.eot && done;
    end
    if (q_pop) begin
      job_r <= q_job;
      pos_r <= 3'd0;
    end
  end

  assign out_tvalid = vld_r;
  assign cp_o       = cp_r;
  assign cw_o       = cw_r;
  assign run_o      = run_r;
  assign last_o     = last_r;

endmodule

### sv/utf8_display_width_counter_core.sv
// ----------------------------------------------------------------------------
// utf8_display_width_counter_core
// UTF-8 decoder that reports each code point with its column width and total.
// ----------------------------------------------------------------------------
// Bytes of a string enter one a word on the input stream, the last one with
// in_tlast. An intake stage buffers an open multi-byte sequence and passes
// each finished sequence through a two-entry queue to a decoder that emits
// one code point a cycle unless stalled, so text flows at one byte a cycle with
// one result per code point. At end of string a cut-off sequence is replayed from
// its lead byte, giving up to three results for that last byte, one a cycle unless
// stalled; the decoder's walk over the buffered bytes sets that cost. out_tlast
// marks the last result of a string; the column total then restarts from zero.
// ----------------------------------------------------------------------------
module utf8_display_width_counter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [u8dw_pkg::IN_DATA_W-1:0]    in_tdata,   // in_byte
  input  logic                              in_tlast,   // end_of_text
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [u8dw_pkg::OUT_DATA_W-1:0]   out_tdata,  // code_point, column_width,
                                                        // running_columns, zero pad
  output logic                              out_tlast   // final_result
);

  logic                              in_acc;
  logic                              f_vld;
  u8dw_pkg::job_t                    f_job;
  logic                              q_full;
  logic                              q_vld;
  logic                              q_pop;
  u8dw_pkg::job_t                    q_job;
  logic [u8dw_pkg::CP_W-1:0]         cp;
  logic [u8dw_pkg::CW_W-1:0]         cw;
  logic [u8dw_pkg::TOTAL_BITS-1:0]   run;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  u8dw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .byte_val (in_tdata),
    .byte_eot (in_tlast),
    .job_vld  (f_vld),
    .job      (f_job)
  );

  u8dw_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_vld),
    .wr_job (f_job),
    .full   (q_full),
    .rd_vld (q_vld),
    .rd_en  (q_pop),
    .rd_job (q_job)
  );

  u8dw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cp_o       (cp),
    .cw_o       (cw),
    .run_o      (run),
    .last_o     (out_tlast)
  );

  assign out_tdata = u8dw_pkg::OUT_DATA_W'({run, cw, cp});

endmodule
